// ----- sv/stc_pkg.sv -----
// Package for the scrolling text console: grid size, character codes,
// sequencer states and the structs passed between the submodules.
// No dependencies.
`timescale 1ns / 1ps

package stc_pkg;

   // grid geometry
   localparam int ROWS      = 20;
   localparam int COLS      = 30;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_W     = $clog2(COLS);
   localparam int RAM_DEPTH = ROWS * (1 << COL_W);
   localparam int ADDR_W    = $clog2(RAM_DEPTH);

   // port field widths
   localparam int CHAR_W = 8;
   localparam int POS_W  = 5;

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

   // character codes
   localparam logic [CHAR_W-1:0] CODE_PRINTABLE = 8'h20;
   localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0a;
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CODE_NULL      = 8'h00;

   // request op codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BLANK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] cell_char;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              full_redraw;
   } result_type;

endpackage

// ----- sv/stc_cell_ram.sv -----
// Character cell store: one write port, one read port, registered read data.
// Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_cell_ram (
   input  logic                          clock,
   input  stc_pkg::ram_req_type          ram_req,
   output logic [stc_pkg::CHAR_W-1:0]    rd_data
);

   logic [stc_pkg::CHAR_W-1:0] mem [0:stc_pkg::RAM_DEPTH-1];
   logic [stc_pkg::CHAR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/stc_ctrl.sv -----
// Cursor state and request sequencer: clear sweep, cell writes, row blanking
// and view reads against the cell store. Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [stc_pkg::CHAR_W-1:0]         req_char_code,
   input  logic [stc_pkg::POS_W-1:0]          req_view_row,
   input  logic [stc_pkg::POS_W-1:0]          req_view_col,
   output stc_pkg::ram_req_type               ram_req,
   input  logic [stc_pkg::CHAR_W-1:0]         rd_data,
   input  logic                               slot_free,
   output stc_pkg::result_type                result
);

   stc_pkg::state_type              state_ff, state_in;
   logic [stc_pkg::ROW_W-1:0]       cur_row_ff, cur_row_in;
   logic [stc_pkg::COL_W-1:0]       cur_col_ff, cur_col_in;
   logic [stc_pkg::ROW_W-1:0]       sweep_row_ff, sweep_row_in;
   logic [stc_pkg::COL_W-1:0]       sweep_col_ff, sweep_col_in;
   logic                            redraw_ff, redraw_in;
   logic                            is_read_ff, is_read_in;
   logic                            read_zero_ff, read_zero_in;

   logic [stc_pkg::ROW_W-1:0]       row_inc;
   logic [stc_pkg::ROW_W-1:0]       row_dec;
   logic [stc_pkg::ROW_W:0]         view_sum;
   logic [stc_pkg::ROW_W-1:0]       view_store_row;
   logic                            view_in_grid;

   // neighbor rows of the cursor
   assign row_inc = (cur_row_ff == stc_pkg::ROW_LAST) ? '0 : cur_row_ff + 1'b1;
   assign row_dec = (cur_row_ff == '0) ? stc_pkg::ROW_LAST : cur_row_ff - 1'b1;

   // view row to store row, sum below twice the row count for in-grid rows
   assign view_sum = {1'b0, cur_row_ff} + {1'b0, stc_pkg::ROW_W'(req_view_row)}
                     + 1'b1;
   assign view_store_row = (32'(view_sum) >= stc_pkg::ROWS)
                         ? stc_pkg::ROW_W'(32'(view_sum) - stc_pkg::ROWS)
                         : stc_pkg::ROW_W'(view_sum);
   assign view_in_grid = (32'(req_view_row) < stc_pkg::ROWS)
                      && (32'(req_view_col) < stc_pkg::COLS);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stc_pkg::ST_CLEAR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         sweep_row_ff <= '0;
         sweep_col_ff <= '0;
         redraw_ff    <= 1'b0;
         is_read_ff   <= 1'b0;
         read_zero_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         sweep_row_ff <= sweep_row_in;
         sweep_col_ff <= sweep_col_in;
         redraw_ff    <= redraw_in;
         is_read_ff   <= is_read_in;
         read_zero_ff <= read_zero_in;
      end
   end

   // next state and store accesses
   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      sweep_row_in = sweep_row_ff;
      sweep_col_in = sweep_col_ff;
      redraw_in    = redraw_ff;
      is_read_in   = is_read_ff;
      read_zero_in = read_zero_ff;
      ram_req      = '0;
      req_ready    = 1'b0;
      result       = '0;

      case (state_ff)
         stc_pkg::ST_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = {sweep_row_ff, sweep_col_ff};
            ram_req.wr_data = stc_pkg::CODE_NULL;
            if (sweep_col_ff == stc_pkg::COL_LAST) begin
               sweep_col_in = '0;
               if (sweep_row_ff == stc_pkg::ROW_LAST) begin
                  sweep_row_in = '0;
                  state_in     = stc_pkg::ST_IDLE;
               end else begin
                  sweep_row_in = sweep_row_ff + 1'b1;
               end
            end else begin
               sweep_col_in = sweep_col_ff + 1'b1;
            end
         end

         stc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in     = stc_pkg::ST_RESULT;
               redraw_in    = 1'b0;
               is_read_in   = (req_op == stc_pkg::OP_READ);
               read_zero_in = 1'b0;
               if (req_op == stc_pkg::OP_READ) begin
                  // read one displayed cell
                  read_zero_in    = !view_in_grid;
                  ram_req.rd_en   = view_in_grid;
                  ram_req.rd_addr = {view_store_row, stc_pkg::COL_W'(req_view_col)};
               end else if (req_char_code >= stc_pkg::CODE_PRINTABLE) begin
                  // store character and advance
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = {cur_row_ff, cur_col_ff};
                  ram_req.wr_data = req_char_code;
                  if (cur_col_ff == stc_pkg::COL_LAST) begin
                     cur_col_in   = '0;
                     cur_row_in   = row_inc;
                     redraw_in    = 1'b1;
                     sweep_col_in = '0;
                     state_in     = stc_pkg::ST_BLANK;
                  end else begin
                     cur_col_in = cur_col_ff + 1'b1;
                  end
               end else if (req_char_code == stc_pkg::CODE_NEWLINE) begin
                  cur_col_in   = '0;
                  cur_row_in   = row_inc;
                  redraw_in    = 1'b1;
                  sweep_col_in = '0;
                  state_in     = stc_pkg::ST_BLANK;
               end else if (req_char_code == stc_pkg::CODE_BACKSPACE) begin
                  // blank current cell and step back
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = {cur_row_ff, cur_col_ff};
                  ram_req.wr_data = stc_pkg::CODE_SPACE;
                  if (cur_col_ff == '0) begin
                     cur_col_in = stc_pkg::COL_LAST;
                     cur_row_in = row_dec;
                     redraw_in  = 1'b1;
                  end else begin
                     cur_col_in = cur_col_ff - 1'b1;
                  end
               end
            end
         end

         stc_pkg::ST_BLANK: begin
            // fill the new cursor row with spaces
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = {cur_row_ff, sweep_col_ff};
            ram_req.wr_data = stc_pkg::CODE_SPACE;
            if (sweep_col_ff == stc_pkg::COL_LAST) begin
               sweep_col_in = '0;
               state_in     = stc_pkg::ST_RESULT;
            end else begin
               sweep_col_in = sweep_col_ff + 1'b1;
            end
         end

         stc_pkg::ST_RESULT: begin
            result.valid       = slot_free;
            result.cell_char   = (is_read_ff && !read_zero_ff) ? rd_data
                                                              : stc_pkg::CODE_NULL;
            result.row         = cur_row_ff;
            result.col         = cur_col_ff;
            result.full_redraw = redraw_ff;
            if (slot_free) begin
               state_in = stc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = stc_pkg::ST_CLEAR;
         end
      endcase
   end

   // store never read and written in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(ram_req.wr_en && ram_req.rd_en))
      else $error("cell store read and write collide");

   // a result only leaves when the output slot can take it
   assert property (@(posedge clock) disable iff (reset)
      result.valid |-> slot_free)
      else $error("result issued into a full output slot");

   // cursor stays inside the grid
   assert property (@(posedge clock) disable iff (reset)
      (32'(cur_row_ff) < stc_pkg::ROWS) && (32'(cur_col_ff) < stc_pkg::COLS))
      else $error("cursor outside grid");

   // an accepted request always leads to blanking or a result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=>
         (state_ff == stc_pkg::ST_BLANK || state_ff == stc_pkg::ST_RESULT))
      else $error("accepted request lost");

   // a redraw is flagged exactly when the row moved by a write
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == stc_pkg::OP_WRITE) |=>
         (redraw_ff == (cur_row_ff != $past(cur_row_ff))))
      else $error("redraw flag does not match row change");

endmodule

// ----- sv/scrolling_text_console.sv -----
// Top level of the scrolling text console: sequencer, cell store and the
// result output register. Depends on stc_pkg, stc_cell_ram, stc_ctrl.
//
//   channel  signals                                      direction
//   req      req_valid/ready, op, char_code, view_row/col  in
//   rsp      rsp_valid/ready, cell_char, cursor_row/col,   out
//            full_redraw
//
// A read, an ignored code, a backspace or a character that stays on its row
// goes from ST_IDLE straight to ST_RESULT; a newline or a character that wraps
// the line first passes ST_BLANK, which fills the new row one cell per cycle
// through the single write port of the cell store.
// After reset the store is cleared by a sweep of ROWS * COLS cells (600)
// during which no request is taken.
// A finished result sits in the output register; the next request is taken
// while it waits, and its result waits in the sequencer until the slot frees.
`timescale 1ns / 1ps

module scrolling_text_console (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [stc_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [stc_pkg::POS_W-1:0]     req_view_row,
   input  logic [stc_pkg::POS_W-1:0]     req_view_col,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [stc_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [stc_pkg::POS_W-1:0]     rsp_cursor_row,
   output logic [stc_pkg::POS_W-1:0]     rsp_cursor_col,
   output logic                          rsp_full_redraw
);

   stc_pkg::ram_req_type              ram_req;
   stc_pkg::result_type               result;
   logic [stc_pkg::CHAR_W-1:0]        rd_data;
   logic                              slot_free;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [stc_pkg::CHAR_W-1:0]        cell_char_ff;
   logic [stc_pkg::POS_W-1:0]         cursor_row_ff;
   logic [stc_pkg::POS_W-1:0]         cursor_col_ff;
   logic                              full_redraw_ff;

   stc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .req_view_row  (req_view_row),
      .req_view_col  (req_view_col),
      .ram_req       (ram_req),
      .rd_data       (rd_data),
      .slot_free     (slot_free),
      .result        (result)
   );

   stc_cell_ram u_cell_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // output slot is free when empty or being drained
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = result.valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (result.valid) begin
         cell_char_ff   <= result.cell_char;
         cursor_row_ff  <= stc_pkg::POS_W'(result.row);
         cursor_col_ff  <= stc_pkg::POS_W'(result.col);
         full_redraw_ff <= result.full_redraw;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_char   = cell_char_ff;
   assign rsp_cursor_row  = cursor_row_ff;
   assign rsp_cursor_col  = cursor_col_ff;
   assign rsp_full_redraw = full_redraw_ff;

endmodule
